// ----- rtl/median_filter_7x7_core_assert.svh -----
// ----------------------------------------------------------------------------
// median_filter_7x7_core_assert.svh
// Assertion macros used by the median filter datapath.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_7X7_CORE_ASSERT_SVH
`define MEDIAN_FILTER_7X7_CORE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define MF7_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MF7_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mf7_pkg.sv -----
// ----------------------------------------------------------------------------
// mf7_pkg
// Shared constants, state type and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mf7_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int RADIUS_DEF    = 3;

    localparam int PIX_W        = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int ROW_W        = 14;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_CHECK,
        S_SETUP,
        S_GATHER,
        S_FLUSH,
        S_RESULT
    } mf7_state_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic check;
        logic setup;
        logic issue;
        logic push;
    } mf7_cmd_t;

    typedef struct packed {
        logic emit;
        logic last_issue;
        logic out_free;
    } mf7_sts_t;

endpackage

// ----- rtl/mf7_ctrl.sv -----
// ----------------------------------------------------------------------------
// mf7_ctrl
// Sequencer: steps one item through position check, window gather and
// median output.
// ----------------------------------------------------------------------------
module mf7_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mf7_pkg::mf7_sts_t sts,
    output mf7_pkg::mf7_cmd_t cmd
);
    import mf7_pkg::*;

    mf7_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                cmd.calc   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.emit ? S_SETUP : S_IDLE;
            end
            S_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = S_GATHER;
            end
            S_GATHER: begin
                cmd.issue = 1'b1;
                if (sts.last_issue) begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/mf7_dp.sv -----
// ----------------------------------------------------------------------------
// mf7_dp
// Datapath: raster counters, line store, window address walk, insertion
// sorter and output register.
// ----------------------------------------------------------------------------
module mf7_dp #(
    parameter int MAX_WIDTH = mf7_pkg::MAX_WIDTH_DEF,
    parameter int RADIUS    = mf7_pkg::RADIUS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mf7_pkg::mf7_cmd_t               cmd,
    output mf7_pkg::mf7_sts_t               sts,
    input  logic                            cfg_wr_en,
    input  logic [mf7_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mf7_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_command,
    input  logic [mf7_pkg::PIX_W-1:0]       in_pixel,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mf7_pkg::PIX_W-1:0]       m_median,
    output logic                            m_last
);
    import mf7_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int LW    = ROW_W + CW;
    localparam int AW    = $clog2(2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1);
    localparam int DEPTH = 1 << AW;
    localparam int WS    = (2 * RADIUS + 1) * (2 * RADIUS + 1);
    localparam int KW    = $clog2(WS + 1);
    localparam int DW    = $clog2(2 * RADIUS + 2);
    localparam int MID   = WS / 2;
    localparam logic [PIX_W:0] EMPTY = {1'b1, {PIX_W{1'b0}}};
    localparam logic [PIX_W:0] PAD_HI = {1'b0, {PIX_W{1'b1}}};

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [CW-1:0]           w;
    logic [HEIGHT_REG_W-1:0] h;

    logic                 cmd_reg;
    logic [PIX_W-1:0]     pix_reg;
    logic [ROW_W-1:0]     in_row_reg, out_row_reg;
    logic [CW-1:0]        in_col_reg, out_col_reg;
    logic [LW-1:0]        total_reg, pin_reg, opos_reg;

    logic [PIX_W-1:0]     mem [DEPTH];
    logic [PIX_W-1:0]     rd_data_reg;
    logic                 ins_valid_reg;
    logic [AW-1:0]        addr_reg;
    logic [DW-1:0]        nr_reg, nc_reg, rc_reg, cc_reg;
    logic [KW-1:0]        k_reg;
    logic [PIX_W:0]       cell_reg [WS];
    logic [PIX_W:0]       cell_next [WS];

    logic                 m_valid_reg, m_last_reg;
    logic [PIX_W-1:0]     m_median_reg;

    logic                 emit, last_issue, out_free;

    // config and effective image size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_IMAGE_WIDTH) begin
                width_reg <= cfg_wdata[WIDTH_REG_W-1:0];
            end
            if (cfg_index == CFG_IMAGE_HEIGHT) begin
                height_reg <= cfg_wdata[HEIGHT_REG_W-1:0];
            end
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            w = CW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(width_reg);
        end
        h = (height_reg == '0) ? HEIGHT_REG_W'(1) : height_reg;
    end

    // check-step decisions
    logic          clr, in_frame, skip;
    logic [LW-1:0] pin_e, opos_e, lag;
    logic [ROW_W-1:0] in_row_e;
    logic [CW-1:0]    in_col_e;
    logic [CW:0]      in_col_inc;

    always_comb begin
        lag = LW'(w) * LW'(RADIUS) + LW'(RADIUS);
        clr = (out_row_reg >= ROW_W'(h)) || (out_col_reg >= w) || (opos_reg >= total_reg);
        pin_e    = clr ? '0 : pin_reg;
        opos_e   = clr ? '0 : opos_reg;
        in_row_e = clr ? '0 : in_row_reg;
        in_col_e = clr ? '0 : in_col_reg;
        in_frame = pin_e < total_reg;
        skip     = in_frame && cmd_reg;
        emit     = !skip && (pin_e >= lag);
        in_col_inc = {1'b0, in_col_e} + (CW+1)'(1);
    end

    // window extent for setup
    logic [DW-1:0]    above, below, left, right, nr, nc;
    logic [ROW_W-1:0] rows_after;
    logic [CW-1:0]    cols_after;
    logic [KW-1:0]    k, z, npad;
    logic [LW-1:0]    start_lin;

    always_comb begin
        rows_after = ROW_W'(h) - ROW_W'(1) - out_row_reg;
        cols_after = w - CW'(1) - out_col_reg;
        above = (out_row_reg < ROW_W'(RADIUS)) ? DW'(out_row_reg) : DW'(RADIUS);
        below = (rows_after  < ROW_W'(RADIUS)) ? DW'(rows_after)  : DW'(RADIUS);
        left  = (out_col_reg < CW'(RADIUS))    ? DW'(out_col_reg) : DW'(RADIUS);
        right = (cols_after  < CW'(RADIUS))    ? DW'(cols_after)  : DW'(RADIUS);
        nr = above + below + DW'(1);
        nc = left + right + DW'(1);
        k  = KW'(nr) * KW'(nc);
        // pad so the median lands on fixed cells: low pads of zero, high
        // pads of full scale, EMPTY above them absorbs the inserts
        npad = KW'(WS) - k;
        z    = npad >> 1;
        start_lin = opos_reg - LW'(above) * LW'(w) - LW'(left);
    end

    // insertion sorter cells
    always_comb begin
        for (int i = 0; i < WS; i++) begin
            if (cell_reg[i] > {1'b0, rd_data_reg}) begin
                if (i == 0) begin
                    cell_next[i] = {1'b0, rd_data_reg};
                end else if (cell_reg[i-1] > {1'b0, rd_data_reg}) begin
                    cell_next[i] = cell_reg[i-1];
                end else begin
                    cell_next[i] = {1'b0, rd_data_reg};
                end
            end else begin
                cell_next[i] = cell_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < WS; i++) begin
            if (cmd.setup) begin
                if (KW'(i) < z) begin
                    cell_reg[i] <= '0;
                end else if (KW'(i) < npad) begin
                    cell_reg[i] <= PAD_HI;
                end else begin
                    cell_reg[i] <= EMPTY;
                end
            end else if (ins_valid_reg) begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    // line store
    always_ff @(posedge aclk) begin
        if (cmd.check && in_frame && !cmd_reg) begin
            mem[pin_e[AW-1:0]] <= pix_reg;
        end
        if (cmd.issue) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign last_issue = (rc_reg == nr_reg - DW'(1)) && (cc_reg == nc_reg - DW'(1));

    // payload and walk registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= in_command;
            pix_reg <= in_pixel;
        end
        if (cmd.calc) begin
            total_reg <= LW'(w) * LW'(h);
            pin_reg   <= LW'(in_row_reg) * LW'(w) + LW'(in_col_reg);
            opos_reg  <= LW'(out_row_reg) * LW'(w) + LW'(out_col_reg);
        end else if (cmd.check) begin
            opos_reg <= opos_e;
        end
        if (cmd.setup) begin
            nr_reg   <= nr;
            nc_reg   <= nc;
            k_reg    <= k;
            rc_reg   <= '0;
            cc_reg   <= '0;
            addr_reg <= start_lin[AW-1:0];
        end else if (cmd.issue) begin
            if (cc_reg == nc_reg - DW'(1)) begin
                cc_reg   <= '0;
                rc_reg   <= rc_reg + DW'(1);
                addr_reg <= addr_reg + AW'(w) - AW'(nc_reg) + AW'(1);
            end else begin
                cc_reg   <= cc_reg + DW'(1);
                addr_reg <= addr_reg + AW'(1);
            end
        end
    end

    // median select on the fixed middle cells
    logic [PIX_W-1:0] med;
    logic [PIX_W+1:0] pair_sum;
    logic             is_last;

    always_comb begin
        pair_sum = (PIX_W+2)'(cell_reg[MID-1]) + (PIX_W+2)'(cell_reg[MID]);
        med      = k_reg[0] ? cell_reg[MID][PIX_W-1:0] : pair_sum[PIX_W:1];
        is_last  = (opos_reg + LW'(1)) >= total_reg;
    end

    assign out_free = !m_valid_reg || m_tready;

    assign sts = '{emit: emit, last_issue: last_issue, out_free: out_free};

    // control state: counters, insert strobe, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            ins_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            ins_valid_reg <= cmd.issue;
            if (cmd.check) begin
                if (clr) begin
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                end
                if (skip) begin
                    in_row_reg <= in_row_e;
                    in_col_reg <= in_col_e;
                end else if (in_col_inc >= {1'b0, w}) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_e + ROW_W'(1);
                end else begin
                    in_col_reg <= in_col_inc[CW-1:0];
                    in_row_reg <= in_row_e;
                end
            end
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
                if (is_last) begin
                    in_row_reg  <= '0;
                    in_col_reg  <= '0;
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                end else if ({1'b0, out_col_reg} + (CW+1)'(1) >= {1'b0, w}) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + ROW_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_median_reg <= med;
            m_last_reg   <= is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_median = m_median_reg;
    assign m_last   = m_last_reg;

`include "median_filter_7x7_core_assert.svh"

    `MF7_ASSERT_NOW(a_insert_room, ins_valid_reg, cell_reg[WS-1] == EMPTY, "sorter overflow")
    `MF7_ASSERT_NOW(a_setup_row, cmd.setup, out_row_reg < ROW_W'(h), "window row outside image")
    `MF7_ASSERT_NOW(a_push_free, cmd.push, out_free, "output overwritten")
    `MF7_ASSERT_NEXT(a_issue_ins, cmd.issue, ins_valid_reg, "read data not inserted")

endmodule

// ----- rtl/median_filter_7x7_core.sv -----
// ----------------------------------------------------------------------------
// median_filter_7x7_core
// Streaming clipped-window 7x7 median filter for 8-bit greyscale rasters.
// ----------------------------------------------------------------------------
// One item at a time. An item that yields no result passes through accept,
// position multiply and check/line store write. An item that yields a result
// adds setup, a gather of k pixels (k = clipped window count, 1 to 49),
// flush and result: the window is gathered from the line store one pixel
// per cycle via its single read port into an insertion sorter. A finished
// median waits in the output register while the next item is accepted.
// After the last pixel send 3*width+3 drain items (tuser = 1) to flush.
module median_filter_7x7_core #(
    parameter int MAX_WIDTH = mf7_pkg::MAX_WIDTH_DEF,
    parameter int RADIUS    = mf7_pkg::RADIUS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel_in
    input  logic                            s_tuser,   // [0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] median_out
    output logic                            m_tlast,   // last_of_frame
    input  logic                            cfg_wr_en,
    input  logic [mf7_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mf7_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import mf7_pkg::*;

    mf7_cmd_t cmd;
    mf7_sts_t sts;

    mf7_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mf7_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_command (s_tuser),
        .in_pixel   (s_tdata[PIX_W-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_median   (m_tdata),
        .m_last     (m_tlast)
    );

endmodule
